// ----- hw/rtl/bdqs_pkg.sv -----
`default_nettype none

package bdqs_pkg;

    // Store geometry
    localparam int DEPTH = 16;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Fixed field widths
    localparam int VALUE_W  = 32;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 4;
    localparam int COUNT_W  = 5;

    // Result packing: status, found, position, count, empty_res, zero fill
    localparam int RES_W      = STATUS_W + 1 + POS_W + COUNT_W + 1;
    localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD_FRONT = 3'd0,
        CMD_ADD_BACK  = 3'd1,
        CMD_REM_FRONT = 3'd2,
        CMD_REM_BACK  = 3'd3,
        CMD_SEARCH    = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic exec;   // run the accepted request
        logic step;   // advance the search scan
        logic emit;   // hand the result to the output register
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic search_req;  // the offered request is a search
        logic scan_done;   // search has its answer
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- hw/rtl/bdqs_ram.sv -----
`default_nettype none

module bdqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  wire logic [WIDTH-1:0]                 i_wdata,
    input  wire logic                             i_re,
    input  wire logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic      [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hw/rtl/bdqs_ctrl.sv -----
`default_nettype none

module bdqs_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_out_free,
    input  wire bdqs_pkg::t_dp_stat   i_stat,
    output logic                      o_in_ready,
    output bdqs_pkg::t_ctrl_cmd       o_cmd
);

    import bdqs_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_stat.search_req ? S_SCAN : S_EMIT;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                // take nothing while reset is held
                o_in_ready = i_rst_n;
                o_cmd.exec = i_in_valid && i_rst_n;
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
            end
            S_EMIT: begin
                o_cmd.emit = i_out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/bdqs_dp.sv -----
`default_nettype none

module bdqs_dp (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire bdqs_pkg::t_ctrl_cmd            i_cmd,
    input  wire logic [bdqs_pkg::CMD_W-1:0]     i_req_cmd,
    input  wire logic [bdqs_pkg::VALUE_W-1:0]   i_req_value,
    output bdqs_pkg::t_dp_stat                  o_stat,
    output logic [bdqs_pkg::STATUS_W-1:0]       o_status,
    output logic                                o_found,
    output logic [bdqs_pkg::POS_W-1:0]          o_position,
    output logic [bdqs_pkg::COUNT_W-1:0]        o_count,
    output logic                                o_empty
);

    import bdqs_pkg::*;

    localparam int SUM_W = CNT_W + 1;

    // Ring index of (head + offset), offset never above DEPTH
    function automatic logic [PTR_W-1:0] ring_at(input logic [PTR_W-1:0] head,
                                                  input logic [CNT_W-1:0] offset);
        logic [SUM_W-1:0] sum;
        begin
            sum = SUM_W'(head) + SUM_W'(offset);
            if (sum >= SUM_W'(DEPTH)) begin
                sum = sum - SUM_W'(DEPTH);
            end
            return PTR_W'(sum);
        end
    endfunction

    logic [PTR_W-1:0]   r_head;
    logic [CNT_W-1:0]   r_count;
    logic [VALUE_W-1:0] r_key;
    logic [CNT_W-1:0]   r_issue_idx;
    logic [CNT_W-1:0]   r_chk_idx;
    logic               r_chk_vld;
    logic [STATUS_W-1:0] r_status;
    logic               r_found;
    logic [CNT_W-1:0]   r_pos;

    t_cmd               req_cmd;
    logic               full;
    logic               is_empty;
    logic               ram_we;
    logic [PTR_W-1:0]   ram_waddr;
    logic               ram_re;
    logic [PTR_W-1:0]   ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;
    logic               hit;
    logic               more;
    logic [PTR_W-1:0]   head_dec;

    assign req_cmd  = t_cmd'(i_req_cmd);
    assign full     = (r_count == CNT_W'(DEPTH));
    assign is_empty = (r_count == '0);
    assign head_dec = (r_head == '0) ? PTR_W'(DEPTH - 1) : r_head - PTR_W'(1);

    // Write port: adds only, when there is room
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = ring_at(r_head, r_count);
        if (i_cmd.exec && !full) begin
            case (req_cmd)
                CMD_ADD_FRONT: begin
                    ram_we    = 1'b1;
                    ram_waddr = head_dec;
                end
                CMD_ADD_BACK: begin
                    ram_we    = 1'b1;
                end
                default: begin
                    ram_we    = 1'b0;
                end
            endcase
        end
    end

    // Scan: one read issued per step, compared one step later
    assign more      = (r_issue_idx < r_count);
    assign ram_re    = i_cmd.step && more;
    assign ram_raddr = ring_at(r_head, r_issue_idx);
    assign hit       = r_chk_vld && (ram_rdata == r_key);

    assign o_stat.search_req = (req_cmd == CMD_SEARCH);
    assign o_stat.scan_done  = hit || (!more && !r_chk_vld);

    bdqs_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_req_value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            case (req_cmd)
                CMD_ADD_FRONT: begin
                    if (!full) begin
                        r_head  <= head_dec;
                        r_count <= r_count + CNT_W'(1);
                    end
                end
                CMD_ADD_BACK: begin
                    if (!full) begin
                        r_count <= r_count + CNT_W'(1);
                    end
                end
                CMD_REM_FRONT: begin
                    if (!is_empty) begin
                        r_head  <= ring_at(r_head, CNT_W'(1));
                        r_count <= r_count - CNT_W'(1);
                    end
                end
                CMD_REM_BACK: begin
                    if (!is_empty) begin
                        r_count <= r_count - CNT_W'(1);
                    end
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_found     <= 1'b0;
            r_pos       <= '0;
            r_key       <= i_req_value;
            r_issue_idx <= '0;
            r_chk_idx   <= '0;
            r_chk_vld   <= 1'b0;
            case (req_cmd) inside
                CMD_ADD_FRONT, CMD_ADD_BACK: begin
                    r_status <= full ? ST_FULL : ST_OK;
                end
                CMD_REM_FRONT, CMD_REM_BACK: begin
                    r_status <= is_empty ? ST_EMPTY : ST_OK;
                end
                default: begin
                    r_status <= ST_OK;
                end
            endcase
        end else if (i_cmd.step) begin
            r_chk_vld <= more;
            r_chk_idx <= r_issue_idx;
            if (more) begin
                r_issue_idx <= r_issue_idx + CNT_W'(1);
            end
            if (hit) begin
                r_found <= 1'b1;
                r_pos   <= r_chk_idx;
            end
        end
    end

    assign o_status   = r_status;
    assign o_found    = r_found;
    assign o_position = POS_W'(r_pos);
    assign o_count    = COUNT_W'(r_count);
    assign o_empty    = is_empty;

endmodule

`default_nettype wire

// ----- hw/rtl/bounded_deque_with_search_unit.sv -----
`default_nettype none

// Bounded double-ended queue of signed 32-bit values with a linear search.
// Each request on the slave stream carries a command in tuser (add front,
// add back, remove front, remove back, search) and a value in tdata; each
// request gives exactly one result on the master stream: a status (ok,
// removal from empty, add to full), a found flag and position from the
// front for searches, and the count and empty flag after the request.
// Removing from an empty store or adding to a full one leaves the store
// unchanged. Requests are handled one at a time. Adds, removals and unused
// command codes pass through two steps: one to accept and update the ring,
// one to load the output register. A search walks the ring through the
// single read port of the entry RAM, one entry per cycle with a registered
// read, and ends at the first match or once every stored entry is compared.
// A new request is taken while the previous result still waits in the
// output register; a result only stalls the block when the output register
// is still full.
module bounded_deque_with_search_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [31:0] value
    input  wire logic [bdqs_pkg::VALUE_W-1:0]        s_axis_tdata,
    // [2:0] cmd
    input  wire logic [bdqs_pkg::CMD_W-1:0]          s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [1:0] status, [2] found, [6:3] position, [11:7] count, [12] empty_res,
    // [15:13] zero
    output logic [bdqs_pkg::OUT_DATA_W-1:0]          m_axis_tdata
);

    import bdqs_pkg::*;

    t_ctrl_cmd            ctrl_cmd;
    t_dp_stat             dp_stat;
    logic                 out_free;
    logic [STATUS_W-1:0]  res_status;
    logic                 res_found;
    logic [POS_W-1:0]     res_position;
    logic [COUNT_W-1:0]   res_count;
    logic                 res_empty;

    logic                 r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    // Output register is free when empty or being taken this cycle
    assign out_free = !r_out_valid || m_axis_tready;

    bdqs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_free (out_free),
        .i_stat     (dp_stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (ctrl_cmd)
    );

    bdqs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (ctrl_cmd),
        .i_req_cmd   (s_axis_tuser),
        .i_req_value (s_axis_tdata),
        .o_stat      (dp_stat),
        .o_status    (res_status),
        .o_found     (res_found),
        .o_position  (res_position),
        .o_count     (res_count),
        .o_empty     (res_empty)
    );

    // Hold the result until the master side takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctrl_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl_cmd.emit) begin
            r_out_data <= OUT_DATA_W'({res_empty, res_count, res_position,
                                       res_found, res_status});
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire
